// ===== hdl/mrr_pkg.sv =====
`default_nettype none
package mrr_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W           = 9;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd200;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [7:0]  FC_EXCEPTION  = 8'h80;
    localparam int          LEN_SHORT     = 1 + 1 + 1 + 2;
    localparam int          LEN_WRITE     = 1 + 1 + 4 + 2;

    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef enum logic [1:0] {
        OP_ARM  = 2'd0,
        OP_BYTE = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] guess_length(input logic [7:0] fn,
                                                      input logic [7:0] count);
        logic [LEN_W-1:0] len;
        priority if (fn >= 8'd1 && fn <= 8'd4) begin
            len = LEN_W'(LEN_SHORT) + {1'b0, count};
        end else if (fn == 8'd5 || fn == 8'd6 || fn == 8'd15 || fn == 8'd16) begin
            len = LEN_W'(LEN_WRITE);
        end else if (fn == 8'd7) begin
            len = LEN_W'(LEN_SHORT);
        end else if (fn >= FC_EXCEPTION) begin
            len = LEN_W'(LEN_SHORT);
        end else begin
            len = '0;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mrr_front.sv =====
`default_nettype none
module mrr_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [1:0]     s_command,
    input  wire logic [7:0]     s_rx_byte,
    output logic                push,
    output mrr_pkg::item_t      push_item,
    input  wire mrr_pkg::q_stat_t q_stat
);
    import mrr_pkg::*;

    logic  f_valid_reg, f_valid_next;
    item_t f_item_reg;
    item_t cls_item;
    logic  cls_valid;
    logic  accept;

    always_comb begin
        cls_item.data = s_rx_byte;
        cls_valid     = 1'b1;
        unique case (s_command)
            CMD_ARM:  cls_item.op = OP_ARM;
            CMD_BYTE: cls_item.op = OP_BYTE;
            CMD_TICK: cls_item.op = OP_TICK;
            default: begin
                // unused command: drop it here
                cls_item.op = OP_TICK;
                cls_valid   = 1'b0;
            end
        endcase
    end

    assign push      = f_valid_reg && !q_stat.full;
    assign push_item = f_item_reg;
    assign s_ready   = !f_valid_reg || !q_stat.full;
    assign accept    = s_valid && s_ready;

    always_comb begin
        if (accept) begin
            f_valid_next = cls_valid;
        end else begin
            f_valid_next = f_valid_reg && !push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f_item_reg <= cls_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mrr_queue.sv =====
`default_nettype none
module mrr_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire mrr_pkg::item_t   push_item,
    output mrr_pkg::q_stat_t      q_stat,
    input  wire logic             pop,
    output mrr_pkg::item_t        pop_item
);
    import mrr_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mrr_back.sv =====
`default_nettype none
module mrr_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [15:0]    cfg_data,
    input  wire mrr_pkg::q_stat_t q_stat,
    input  wire mrr_pkg::item_t pop_item,
    output logic                pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_data_byte,
    output logic [7:0]          m_byte_index,
    output logic [8:0]          m_payload_length,
    output logic [8:0]          m_guessed_length,
    output logic                m_by_timeout,
    output logic                m_overflow
);
    import mrr_pkg::*;

    logic [15:0]      timeout_reg;
    logic             receiving_reg, receiving_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       fn_reg, fn_next;
    logic [LEN_W-1:0] exp_reg, exp_next;
    logic [15:0]      idle_reg, idle_next;
    logic             dropped_reg, dropped_next;

    logic             m_valid_reg, m_valid_next;
    kind_t            kind_reg;
    logic [7:0]       data_reg;
    logic [7:0]       index_reg;
    logic [8:0]       plen_reg;
    logic [8:0]       glen_reg;
    logic             bytime_reg;
    logic             ovf_reg;

    logic             res_valid;
    kind_t            res_kind;
    logic [7:0]       res_data;
    logic [7:0]       res_index;
    logic [8:0]       res_plen;
    logic             res_bytime;
    logic             by_len, by_time;

    assign cfg_ready = 1'b1;
    assign pop       = !q_stat.empty && (!m_valid_reg || m_ready);

    always_comb begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        fn_next        = fn_reg;
        exp_next       = exp_reg;
        idle_next      = idle_reg;
        dropped_next   = dropped_reg;
        res_valid      = 1'b0;
        res_kind       = KIND_ECHO;
        res_data       = '0;
        res_index      = '0;
        res_plen       = '0;
        res_bytime     = 1'b0;
        by_len         = 1'b0;
        by_time        = 1'b0;
        if (pop) begin
            unique case (pop_item.op)
                OP_ARM: begin
                    // restart the frame, dropping any in progress
                    receiving_next = 1'b1;
                    count_next     = '0;
                    crc_next       = CRC_INIT;
                    fn_next        = '0;
                    exp_next       = '0;
                    idle_next      = '0;
                    dropped_next   = 1'b0;
                end
                OP_BYTE: begin
                    if (receiving_reg) begin
                        idle_next = '0;
                        if (count_reg >= CNT_W'(MAX_FRAME_BYTES)) begin
                            dropped_next = 1'b1;
                        end else begin
                            crc_next = crc_fold(crc_reg, pop_item.data);
                            if (count_reg == CNT_W'(1)) begin
                                fn_next = pop_item.data;
                            end
                            if (count_reg == CNT_W'(2) && exp_reg == '0) begin
                                exp_next = guess_length(fn_reg, pop_item.data);
                            end
                            count_next = count_reg + 1'b1;
                            res_valid  = 1'b1;
                            res_kind   = KIND_ECHO;
                            res_data   = pop_item.data;
                            res_index  = count_reg[7:0];
                        end
                    end
                end
                OP_TICK: begin
                    if (receiving_reg) begin
                        if (idle_reg != IDLE_MAX) begin
                            idle_next = idle_reg + 1'b1;
                        end
                        by_len  = (exp_reg != '0) && (LEN_W'(count_reg) >= exp_reg);
                        by_time = idle_next > timeout_reg;
                        if (by_len || by_time) begin
                            res_valid      = 1'b1;
                            res_kind       = (crc_reg == '0 && count_reg >= CNT_W'(2))
                                             ? KIND_GOOD : KIND_BAD;
                            res_plen       = (count_reg >= CNT_W'(2))
                                             ? 9'(count_reg - CNT_W'(2)) : '0;
                            res_bytime     = !by_len;
                            receiving_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (pop) begin
            m_valid_next = res_valid;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RESET;
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            crc_reg       <= CRC_INIT;
            fn_reg        <= '0;
            exp_reg       <= '0;
            idle_reg      <= '0;
            dropped_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            fn_reg        <= fn_next;
            exp_reg       <= exp_next;
            idle_reg      <= idle_next;
            dropped_reg   <= dropped_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // load the result register only when a new item lands in it
    always_ff @(posedge aclk) begin
        if (pop && res_valid) begin
            kind_reg   <= res_kind;
            data_reg   <= res_data;
            index_reg  <= res_index;
            plen_reg   <= res_plen;
            glen_reg   <= 9'(exp_next);
            bytime_reg <= res_bytime;
            ovf_reg    <= dropped_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_data_byte      = data_reg;
    assign m_byte_index     = index_reg;
    assign m_payload_length = plen_reg;
    assign m_guessed_length = glen_reg;
    assign m_by_timeout     = bytime_reg;
    assign m_overflow       = ovf_reg;

endmodule
`default_nettype wire

// ===== hdl/modbus_rtu_response_receiver_core.sv =====
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_command, s_rx_byte
// m_        out        m_valid / m_ready      kind, data_byte, byte_index, lengths, flags
// cfg_      in         cfg_valid / cfg_ready  cfg_data (timeout_ms)
//
// One item per cycle sustained while m_ready stays high; from input accept to
// result an item passes the classify register, the two-entry queue and the
// result register. CRC fold and frame bookkeeping happen as an item is popped.
// Reset is synchronous on aresetn low; timeout_ms returns to 200, no frame armed.
// A stalled m_ blocks the back end; the queue and front register then fill and
// drop s_ready. cfg_ready is always high.
`default_nettype none
module modbus_rtu_response_receiver_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_data_byte,
    output logic [7:0]       m_byte_index,
    output logic [8:0]       m_payload_length,
    output logic [8:0]       m_guessed_length,
    output logic             m_by_timeout,
    output logic             m_overflow,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import mrr_pkg::*;

    logic    push;
    item_t   push_item;
    q_stat_t q_stat;
    logic    pop;
    item_t   pop_item;

    mrr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_rx_byte (s_rx_byte),
        .push      (push),
        .push_item (push_item),
        .q_stat    (q_stat)
    );

    mrr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .q_stat    (q_stat),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    mrr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .q_stat           (q_stat),
        .pop_item         (pop_item),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_byte_index     (m_byte_index),
        .m_payload_length (m_payload_length),
        .m_guessed_length (m_guessed_length),
        .m_by_timeout     (m_by_timeout),
        .m_overflow       (m_overflow)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_stat.full))
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_stat.empty))
        else $error("pop from empty queue");

    a_unused_cmd_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_NONE) |=> !push)
        else $error("unused command reached the queue");

    a_frame_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_ECHO) |-> (m_data_byte == 8'd0 && m_byte_index == 8'd0))
        else $error("frame result carries byte fields");

    a_echo_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_ECHO) |-> (m_payload_length == 9'd0 && !m_by_timeout))
        else $error("echo result carries frame fields");

endmodule
`default_nettype wire
